// File: hw/rtl/wsmh_pkg.sv
package wsmh_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned RegAddrW = 4;
  localparam int unsigned RegDepth = 1 << RegAddrW;

  typedef struct packed {
    logic [1:0]       op;
    logic [WordW-1:0] word;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_0;
    logic [WordW-1:0] digest_1;
    logic [WordW-1:0] digest_2;
    logic [WordW-1:0] digest_3;
    logic [WordW-1:0] folded;
  } result_t;

  localparam logic [1:0] OP_ABSORB     = 2'd0;
  localparam logic [1:0] OP_ABSORB_FIN = 2'd1;
  localparam logic [1:0] OP_FIN        = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  localparam logic [WordW-1:0] K_PI  = 64'h3243F6A8885A308D;
  localparam logic [WordW-1:0] K_E   = 64'h2B7E151628AE06EE;
  localparam logic [WordW-1:0] K_PHI = 64'h19E3779B97F4A7C1;
  localparam logic [WordW-1:0] K_CR  = 64'hDC743EE6B2D64695;
  localparam logic [WordW-1:0] K_MIX = 64'(K_PI * K_E * K_PHI * K_CR);
  localparam logic [WordW-1:0] K_PI2 = 64'(K_PI * 64'd2);
  localparam logic [WordW-1:0] K_E5  = 64'(K_E * 64'd5);
  localparam logic [WordW-1:0] K_PHI3 = 64'(K_PHI * 64'd3);

  localparam logic [2:0] KI_PI   = 3'd0;
  localparam logic [2:0] KI_E    = 3'd1;
  localparam logic [2:0] KI_PHI  = 3'd2;
  localparam logic [2:0] KI_CR   = 3'd3;
  localparam logic [2:0] KI_MIX  = 3'd4;
  localparam logic [2:0] KI_PI2  = 3'd5;
  localparam logic [2:0] KI_E5   = 3'd6;
  localparam logic [2:0] KI_PHI3 = 3'd7;

  localparam logic [WordW-1:0] KONST [8] = '{K_PI, K_E, K_PHI, K_CR, K_MIX, K_PI2, K_E5, K_PHI3};

  // unit operations
  localparam logic [3:0] U_ADD  = 4'd0;
  localparam logic [3:0] U_SUB  = 4'd1;
  localparam logic [3:0] U_XOR  = 4'd2;
  localparam logic [3:0] U_OR1  = 4'd3;
  localparam logic [3:0] U_SHL  = 4'd4;
  localparam logic [3:0] U_SHR  = 4'd5;
  localparam logic [3:0] U_MOVB = 4'd6;
  localparam logic [3:0] U_PASS = 4'd7;
  localparam logic [3:0] U_MUL  = 4'd8;
  localparam logic [3:0] U_MOD  = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] sh;
  } alu_ctl_t;

  // register file slots
  localparam logic [RegAddrW-1:0] R_S0 = 4'd0;
  localparam logic [RegAddrW-1:0] R_S1 = 4'd1;
  localparam logic [RegAddrW-1:0] R_S2 = 4'd2;
  localparam logic [RegAddrW-1:0] R_S3 = 4'd3;
  localparam logic [RegAddrW-1:0] R_M  = 4'd4;
  localparam logic [RegAddrW-1:0] R_W  = 4'd5;
  localparam logic [RegAddrW-1:0] R_T0 = 4'd6;
  localparam logic [RegAddrW-1:0] R_T1 = 4'd7;
  localparam logic [RegAddrW-1:0] R_T2 = 4'd8;
  localparam logic [RegAddrW-1:0] R_T3 = 4'd9;

  localparam logic [2:0] EM_NONE = 3'd0;
  localparam logic [2:0] EM_D0   = 3'd1;
  localparam logic [2:0] EM_D1   = 3'd2;
  localparam logic [2:0] EM_D2   = 3'd3;
  localparam logic [2:0] EM_D3   = 3'd4;
  localparam logic [2:0] EM_FOLD = 3'd5;

  typedef struct packed {
    logic [3:0]          op;
    logic [RegAddrW-1:0] dst;
    logic [RegAddrW-1:0] ra;
    logic [RegAddrW-1:0] rb;
    logic                imm;
    logic [2:0]          kidx;
    logic [3:0]          sh;
    logic [2:0]          emit;
    logic                last;
  } uop_t;

  function automatic uop_t rr(logic [3:0] op, logic [RegAddrW-1:0] dst,
                              logic [RegAddrW-1:0] a, logic [RegAddrW-1:0] b,
                              logic lst = 1'b0);
    uop_t u;
    u = '{op: op, dst: dst, ra: a, rb: b, imm: 1'b0, kidx: KI_PI, sh: 4'd0,
          emit: EM_NONE, last: lst};
    return u;
  endfunction

  function automatic uop_t ri(logic [3:0] op, logic [RegAddrW-1:0] dst,
                              logic [RegAddrW-1:0] a, logic [2:0] k,
                              logic lst = 1'b0);
    uop_t u;
    u = '{op: op, dst: dst, ra: a, rb: R_S0, imm: 1'b1, kidx: k, sh: 4'd0,
          emit: EM_NONE, last: lst};
    return u;
  endfunction

  function automatic uop_t rs(logic [3:0] op, logic [RegAddrW-1:0] dst,
                              logic [RegAddrW-1:0] a, logic [3:0] n);
    uop_t u;
    u = '{op: op, dst: dst, ra: a, rb: R_S0, imm: 1'b0, kidx: KI_PI, sh: n,
          emit: EM_NONE, last: 1'b0};
    return u;
  endfunction

  function automatic uop_t em(logic [3:0] op, logic [RegAddrW-1:0] a,
                              logic [RegAddrW-1:0] b, logic [2:0] code,
                              logic lst = 1'b0);
    uop_t u;
    u = '{op: op, dst: R_T3, ra: a, rb: b, imm: 1'b0, kidx: KI_PI, sh: 4'd0,
          emit: code, last: lst};
    return u;
  endfunction

  localparam int unsigned ProgLen = 149;
  localparam int unsigned PcW = $clog2(ProgLen);
  localparam logic [PcW-1:0] PC_RESTART = PcW'(0);
  localparam logic [PcW-1:0] PC_ABSORB  = PcW'(5);
  localparam logic [PcW-1:0] PC_FINISH  = PcW'(122);

  localparam uop_t PROG [ProgLen] = '{
    // restart
    ri(U_MOVB, R_S0, R_S0, KI_PI),
    ri(U_MOVB, R_S1, R_S0, KI_E),
    ri(U_MOVB, R_S2, R_S0, KI_PHI),
    ri(U_MOVB, R_S3, R_S0, KI_CR),
    ri(U_MOVB, R_M,  R_S0, KI_MIX, 1'b1),
    // absorb, first round
    rs(U_SHL, R_T0, R_S0, 4'd3),
    rr(U_ADD, R_T1, R_W, R_S1),
    rr(U_MUL, R_T0, R_T0, R_T1),
    rr(U_ADD, R_T0, R_T0, R_S1),
    rr(U_ADD, R_T0, R_T0, R_M),
    rr(U_XOR, R_S0, R_S0, R_T0),
    rs(U_SHL, R_T0, R_S1, 4'd5),
    rr(U_ADD, R_T1, R_W, R_S2),
    rr(U_MUL, R_T0, R_T0, R_T1),
    rr(U_ADD, R_T0, R_T0, R_S3),
    rr(U_SUB, R_T0, R_T0, R_M),
    rr(U_XOR, R_S1, R_S1, R_T0),
    rs(U_SHL, R_T0, R_S2, 4'd7),
    rr(U_ADD, R_T1, R_W, R_S3),
    rr(U_MUL, R_T0, R_T0, R_T1),
    rr(U_ADD, R_T0, R_T0, R_S0),
    rr(U_SUB, R_T0, R_T0, R_M),
    rr(U_XOR, R_S2, R_S2, R_T0),
    rs(U_SHL, R_T0, R_S3, 4'd11),
    rr(U_ADD, R_T1, R_W, R_S0),
    rr(U_MUL, R_T0, R_T0, R_T1),
    rr(U_ADD, R_T0, R_T0, R_S2),
    rr(U_ADD, R_T0, R_T0, R_M),
    rr(U_XOR, R_S3, R_S3, R_T0),
    rr(U_MUL, R_T0, R_S0, R_S1),
    rr(U_MUL, R_T0, R_T0, R_S2),
    rr(U_MUL, R_T0, R_T0, R_S3),
    rr(U_MUL, R_T0, R_T0, R_S0),
    rr(U_ADD, R_T0, R_T0, R_S1),
    rr(U_ADD, R_T0, R_T0, R_S2),
    rr(U_ADD, R_T0, R_T0, R_S3),
    rr(U_ADD, R_M,  R_T0, R_M),
    // second round
    ri(U_MUL, R_T0, R_S2, KI_CR),
    rr(U_OR1, R_T1, R_S1, R_S1),
    rr(U_MOD, R_T0, R_T0, R_T1),
    rs(U_SHR, R_T1, R_S1, 4'd3),
    rr(U_MUL, R_T1, R_S0, R_T1),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_MUL, R_T1, R_W, R_S3),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_ADD, R_S0, R_T0, R_M),
    ri(U_MUL, R_T0, R_S3, KI_E),
    rr(U_OR1, R_T1, R_S2, R_S2),
    rr(U_MOD, R_T0, R_T0, R_T1),
    rs(U_SHR, R_T1, R_S3, 4'd5),
    rr(U_MUL, R_T1, R_S1, R_T1),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_MUL, R_T1, R_W, R_S0),
    rr(U_MUL, R_T1, R_T1, R_M),
    rr(U_ADD, R_S1, R_T0, R_T1),
    ri(U_MUL, R_T0, R_S0, KI_PHI),
    rr(U_OR1, R_T1, R_S3, R_S3),
    rr(U_MOD, R_T0, R_T0, R_T1),
    rs(U_SHR, R_T1, R_S0, 4'd7),
    rr(U_MUL, R_T1, R_S2, R_T1),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_MUL, R_T1, R_W, R_S1),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_ADD, R_S2, R_T0, R_M),
    ri(U_MUL, R_T0, R_S1, KI_PI),
    rr(U_OR1, R_T1, R_S0, R_S0),
    rr(U_MOD, R_T0, R_T0, R_T1),
    rs(U_SHR, R_T1, R_S2, 4'd11),
    rr(U_MUL, R_T1, R_S3, R_T1),
    rr(U_ADD, R_T0, R_T0, R_T1),
    rr(U_MUL, R_T1, R_W, R_S2),
    rr(U_MUL, R_T1, R_T1, R_M),
    rr(U_ADD, R_S3, R_T0, R_T1),
    // third round
    rr(U_MUL, R_T0, R_S0, R_S1),
    rr(U_MUL, R_T0, R_T0, R_S2),
    rr(U_MUL, R_T0, R_T0, R_S3),
    rr(U_ADD, R_T1, R_S0, R_S1),
    rr(U_ADD, R_T1, R_T1, R_S2),
    rr(U_ADD, R_T1, R_T1, R_S3),
    rr(U_OR1, R_T1, R_T1, R_T1),
    rr(U_MOD, R_T0, R_T0, R_T1),
    rr(U_SUB, R_M,  R_T0, R_M),
    ri(U_XOR, R_T0, R_S0, KI_PHI),
    ri(U_MUL, R_T0, R_T0, KI_E),
    rr(U_OR1, R_T1, R_S1, R_S1),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_MUL, R_T1, R_S3, KI_PI),
    rr(U_MUL, R_T2, R_M, R_S0),
    rr(U_ADD, R_T1, R_T1, R_T2),
    rr(U_XOR, R_S0, R_T0, R_T1),
    ri(U_XOR, R_T0, R_S1, KI_CR),
    ri(U_MUL, R_T0, R_T0, KI_PHI),
    rr(U_OR1, R_T1, R_S3, R_S3),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_MUL, R_T1, R_S2, KI_CR),
    rr(U_MUL, R_T2, R_M, R_S1),
    rr(U_SUB, R_T1, R_T1, R_T2),
    rr(U_XOR, R_S1, R_T0, R_T1),
    ri(U_XOR, R_T0, R_S2, KI_E),
    ri(U_MUL, R_T0, R_T0, KI_PI),
    rr(U_OR1, R_T1, R_S0, R_S0),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_MUL, R_T1, R_S0, KI_E),
    rr(U_MUL, R_T2, R_M, R_S2),
    rr(U_ADD, R_T1, R_T1, R_T2),
    rr(U_XOR, R_S2, R_T0, R_T1),
    ri(U_XOR, R_T0, R_S3, KI_PI),
    ri(U_MUL, R_T0, R_T0, KI_CR),
    rr(U_OR1, R_T1, R_S2, R_S2),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_MUL, R_T1, R_S1, KI_PHI),
    rr(U_MUL, R_T2, R_M, R_S3),
    rr(U_SUB, R_T1, R_T1, R_T2),
    rr(U_XOR, R_S3, R_T0, R_T1),
    rr(U_MUL, R_T0, R_S0, R_S1),
    rr(U_MUL, R_T0, R_T0, R_S2),
    rr(U_MUL, R_T0, R_T0, R_S3),
    rr(U_ADD, R_T1, R_S0, R_S1),
    rr(U_ADD, R_T1, R_T1, R_S2),
    rr(U_ADD, R_T1, R_T1, R_S3),
    rr(U_XOR, R_T0, R_T0, R_T1),
    rr(U_XOR, R_M,  R_T0, R_M, 1'b1),
    // finish
    ri(U_XOR, R_T0, R_S0, KI_PHI),
    ri(U_MUL, R_T0, R_T0, KI_E),
    rr(U_OR1, R_T1, R_S1, R_S1),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_XOR, R_S0, R_T0, KI_PI2),
    ri(U_XOR, R_T0, R_S1, KI_PI),
    ri(U_MUL, R_T0, R_T0, KI_PHI),
    rr(U_OR1, R_T1, R_S3, R_S3),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_XOR, R_S1, R_T0, KI_E5),
    ri(U_XOR, R_T0, R_S2, KI_CR),
    ri(U_MUL, R_T0, R_T0, KI_PI),
    rr(U_OR1, R_T1, R_S0, R_S0),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_XOR, R_S2, R_T0, KI_CR),
    ri(U_XOR, R_T0, R_S3, KI_PI),
    ri(U_MUL, R_T0, R_T0, KI_E),
    rr(U_OR1, R_T1, R_S1, R_S1),
    rr(U_MOD, R_T0, R_T0, R_T1),
    ri(U_XOR, R_S3, R_T0, KI_PHI3),
    em(U_PASS, R_S0, R_S0, EM_D0),
    em(U_PASS, R_S1, R_S1, EM_D1),
    em(U_PASS, R_S2, R_S2, EM_D2),
    em(U_PASS, R_S3, R_S3, EM_D3),
    rr(U_XOR, R_T0, R_S0, R_S1),
    rr(U_XOR, R_T0, R_T0, R_S2),
    em(U_XOR, R_T0, R_S3, EM_FOLD, 1'b1)
  };

endpackage

// File: hw/rtl/wsmh_alu.sv
module wsmh_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  wsmh_pkg::alu_ctl_t          ctl,
  input  logic [wsmh_pkg::WordW-1:0]  a,
  input  logic [wsmh_pkg::WordW-1:0]  b,
  output logic                        done,
  output logic [wsmh_pkg::WordW-1:0]  res
);
  import wsmh_pkg::*;

  localparam int unsigned HalfW = WordW / 2;
  localparam int unsigned CntW = $clog2(WordW);

  logic             run;
  logic [3:0]       op_r;
  logic [CntW-1:0]  cnt;
  logic [WordW-1:0] xa;
  logic [WordW-1:0] xb;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] rem;

  logic [HalfW-1:0] mx;
  logic [HalfW-1:0] my;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] acc_next;
  logic [WordW:0]   trial;
  logic [WordW-1:0] rem_next;
  logic [WordW-1:0] simple;

  // 64x64 low product from three 32x32 partial products
  always_comb begin
    unique case (cnt[1:0])
      2'd0:    begin mx = xa[HalfW-1:0];     my = xb[HalfW-1:0];     end
      2'd1:    begin mx = xa[HalfW-1:0];     my = xb[WordW-1:HalfW]; end
      default: begin mx = xa[WordW-1:HalfW]; my = xb[HalfW-1:0];     end
    endcase
    prod = WordW'(mx) * WordW'(my);
    if (cnt == '0) begin
      acc_next = prod;
    end else begin
      acc_next = acc + {prod[HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  // one remainder bit per cycle
  always_comb begin
    trial = {rem, xa[WordW-1]};
    if (trial >= {1'b0, xb}) begin
      rem_next = WordW'(trial - {1'b0, xb});
    end else begin
      rem_next = trial[WordW-1:0];
    end
  end

  always_comb begin
    unique case (ctl.op)
      U_ADD:   simple = a + b;
      U_SUB:   simple = a - b;
      U_XOR:   simple = a ^ b;
      U_OR1:   simple = a | WordW'(1);
      U_SHL:   simple = a << ctl.sh;
      U_SHR:   simple = a >> ctl.sh;
      U_MOVB:  simple = b;
      default: simple = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        op_r <= ctl.op;
        xa   <= a;
        xb   <= b;
        cnt  <= '0;
        rem  <= '0;
        if (ctl.op == U_MUL || ctl.op == U_MOD) begin
          run  <= 1'b1;
          done <= 1'b0;
        end else begin
          res  <= simple;
          done <= 1'b1;
        end
      end else if (run) begin
        cnt <= cnt + CntW'(1);
        if (op_r == U_MUL) begin
          acc <= acc_next;
          if (cnt == CntW'(2)) begin
            res  <= acc_next;
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            done <= 1'b0;
          end
        end else begin
          rem <= rem_next;
          xa  <= xa << 1;
          if (cnt == CntW'(WordW - 1)) begin
            res  <= rem_next;
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            done <= 1'b0;
          end
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/word_stream_mix_hash_256.sv
// word_stream_mix_hash_256: 256-bit mixing hash over a stream of 64-bit words
// request channel (item_valid, item_stall, item): op and word. op 0 absorbs the
// word, op 1 absorbs it and finishes, op 2 finishes with no word, op 3 does nothing.
// result channel (result_valid, result_stall, result): the four digest words and
// their xor fold, one result per finishing request, none otherwise.
// one request at a time: item_stall is high from acceptance until its work is done.
// every step is a microcode word run on one shared unit; a 64-bit multiply is built
// from three 32x32 partial products, a modulo yields one remainder bit a cycle, and
// op 3 is taken without running any microcode.
// the result sits in an output register; the block accepts the next request while
// it waits, and only stalls its own finish step while an earlier result is untaken.
// after reset and after each finish the lanes are loaded by a 5-step pass before
// the next request is taken.
module word_stream_mix_hash_256 (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wsmh_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output wsmh_pkg::result_t result
);
  import wsmh_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]       st;
  logic [PcW-1:0]   pc;
  logic             fin;
  logic [WordW-1:0] rf [RegDepth];
  logic [WordW-1:0] rda;
  logic [WordW-1:0] rdb;

  uop_t             u;
  logic             accept;
  logic             alu_start;
  logic             alu_done;
  logic [WordW-1:0] alu_res;
  logic [WordW-1:0] opb;
  alu_ctl_t         ctl;
  logic             wr_en;
  logic [RegAddrW-1:0] wr_addr;
  logic [WordW-1:0] wr_data;

  assign u          = PROG[pc];
  assign item_stall = (st != ST_IDLE);
  assign accept     = item_valid && (st == ST_IDLE);
  assign opb        = u.imm ? KONST[u.kidx] : rdb;
  assign ctl        = '{op: u.op, sh: u.sh};
  assign alu_start  = (st == ST_EXEC) && !((u.emit != EM_NONE) && result_valid);

  always_comb begin
    if (accept) begin
      wr_en   = 1'b1;
      wr_addr = R_W;
      wr_data = item.word;
    end else begin
      wr_en   = (st == ST_WAIT) && alu_done;
      wr_addr = u.dst;
      wr_data = alu_res;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf[wr_addr] <= wr_data;
    end
    if (st == ST_FETCH) begin
      rda <= rf[u.ra];
      rdb <= rf[u.rb];
    end
  end

  wsmh_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .ctl   (ctl),
    .a     (rda),
    .b     (opb),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_FETCH;
      pc           <= PC_RESTART;
      fin          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (item_valid) begin
            unique case (item.op)
              OP_ABSORB: begin
                pc  <= PC_ABSORB;
                fin <= 1'b0;
                st  <= ST_FETCH;
              end
              OP_ABSORB_FIN: begin
                pc  <= PC_ABSORB;
                fin <= 1'b1;
                st  <= ST_FETCH;
              end
              OP_FIN: begin
                pc  <= PC_FINISH;
                fin <= 1'b0;
                st  <= ST_FETCH;
              end
              default: st <= ST_IDLE;
            endcase
          end
        end
        ST_FETCH: st <= ST_EXEC;
        ST_EXEC: begin
          if (alu_start) begin
            st <= ST_WAIT;
          end
        end
        default: begin
          if (alu_done) begin
            unique case (u.emit)
              EM_D0:   result.digest_0 <= alu_res;
              EM_D1:   result.digest_1 <= alu_res;
              EM_D2:   result.digest_2 <= alu_res;
              EM_D3:   result.digest_3 <= alu_res;
              EM_FOLD: begin
                result.folded <= alu_res;
                result_valid  <= 1'b1;
              end
              default: ;
            endcase
            if (u.last) begin
              if (fin) begin
                fin <= 1'b0;
                pc  <= PC_FINISH;
                st  <= ST_FETCH;
              end else if (pc >= PC_FINISH) begin
                pc <= PC_RESTART;
                st <= ST_FETCH;
              end else begin
                st <= ST_IDLE;
              end
            end else begin
              pc <= pc + PcW'(1);
              st <= ST_FETCH;
            end
          end
        end
      endcase
    end
  end

endmodule

// File: verif/wsmh_checker.sv
`timescale 1ns / 100ps

module wsmh_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  wsmh_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  wsmh_pkg::result_t result,
  output int                fail_count,
  output int                digests_pending
);
  import wsmh_pkg::*;

  logic [63:0] ln_a, ln_b, ln_c, ln_d, mix;
  result_t digest_q[$];

  assign digests_pending = digest_q.size();

  task automatic lanes_restart();
    ln_a = K_PI;
    ln_b = K_E;
    ln_c = K_PHI;
    ln_d = K_CR;
    mix  = 64'(K_PI * K_E * K_PHI * K_CR);
  endtask

  task automatic absorb_word(input logic [63:0] w);
    logic [63:0] s0, s1, s2, s3, m;
    s0 = ln_a; s1 = ln_b; s2 = ln_c; s3 = ln_d; m = mix;
    s0 = s0 ^ (((s0 << 3) * (w + s1)) + s1 + m);
    s1 = s1 ^ (((s1 << 5) * (w + s2)) + s3 - m);
    s2 = s2 ^ (((s2 << 7) * (w + s3)) + s0 - m);
    s3 = s3 ^ (((s3 << 11) * (w + s0)) + s2 + m);
    m = (s0 * s1 * s2 * s3 * s0 + s1 + s2 + s3) + m;
    s0 = ((64'(K_CR * s2)) % (s1 | 64'd1)) + s0 * (s1 >> 3) + w * s3 + m;
    s1 = ((64'(K_E * s3)) % (s2 | 64'd1)) + s1 * (s3 >> 5) + w * s0 * m;
    s2 = ((64'(K_PHI * s0)) % (s3 | 64'd1)) + s2 * (s0 >> 7) + w * s1 + m;
    s3 = ((64'(K_PI * s1)) % (s0 | 64'd1)) + s3 * (s2 >> 11) + w * s2 * m;
    m = (64'(s0 * s1 * s2 * s3)) % (64'(s0 + s1 + s2 + s3) | 64'd1) - m;
    s0 = ((64'((s0 ^ K_PHI) * K_E)) % (s1 | 64'd1)) ^ 64'(K_PI * s3 + m * s0);
    s1 = ((64'((s1 ^ K_CR) * K_PHI)) % (s3 | 64'd1)) ^ 64'(K_CR * s2 - m * s1);
    s2 = ((64'((s2 ^ K_E) * K_PI)) % (s0 | 64'd1)) ^ 64'(K_E * s0 + m * s2);
    s3 = ((64'((s3 ^ K_PI) * K_CR)) % (s2 | 64'd1)) ^ 64'(K_PHI * s1 - m * s3);
    m = 64'(s0 * s1 * s2 * s3) ^ 64'(s0 + s1 + s2 + s3) ^ m;
    ln_a = s0; ln_b = s1; ln_c = s2; ln_d = s3; mix = m;
  endtask

  task automatic finalise_digest();
    logic [63:0] s0, s1, s2, s3;
    result_t r;
    s0 = ln_a; s1 = ln_b; s2 = ln_c; s3 = ln_d;
    s0 = ((64'((s0 ^ K_PHI) * K_E)) % (s1 | 64'd1)) ^ 64'(K_PI * 64'd2);
    s1 = ((64'((s1 ^ K_PI) * K_PHI)) % (s3 | 64'd1)) ^ 64'(K_E * 64'd5);
    s2 = ((64'((s2 ^ K_CR) * K_PI)) % (s0 | 64'd1)) ^ K_CR;
    s3 = ((64'((s3 ^ K_PI) * K_E)) % (s1 | 64'd1)) ^ 64'(K_PHI * 64'd3);
    r.digest_0 = s0;
    r.digest_1 = s1;
    r.digest_2 = s2;
    r.digest_3 = s3;
    r.folded = s0 ^ s1 ^ s2 ^ s3;
    digest_q.push_back(r);
    lanes_restart();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    lanes_restart();
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lanes_restart();
    end else begin
      if (result_valid && !result_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest", result.folded, '0);
        end else begin
          want = digest_q.pop_front();
          if (result.digest_0 !== want.digest_0)
            report_mismatch("digest_0", result.digest_0, want.digest_0);
          if (result.digest_1 !== want.digest_1)
            report_mismatch("digest_1", result.digest_1, want.digest_1);
          if (result.digest_2 !== want.digest_2)
            report_mismatch("digest_2", result.digest_2, want.digest_2);
          if (result.digest_3 !== want.digest_3)
            report_mismatch("digest_3", result.digest_3, want.digest_3);
          if (result.folded !== want.folded)
            report_mismatch("folded", result.folded, want.folded);
        end
      end
      if (item_valid && !item_stall) begin
        case (item.op)
          OP_ABSORB: begin
            absorb_word(item.word);
          end
          OP_ABSORB_FIN: begin
            absorb_word(item.word);
            finalise_digest();
          end
          OP_FIN: begin
            finalise_digest();
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: verif/tb_word_stream_mix_hash_256.sv
`timescale 1ns / 100ps

module tb_word_stream_mix_hash_256;
  import wsmh_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  int fail_count;
  int digests_pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  word_stream_mix_hash_256 dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  wsmh_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .digests_pending(digests_pending)
  );

  always @(negedge clk) begin
    if (!rst) result_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [63:0] w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    item_valid <= 1'b1;
    item <= '{op: op, word: w};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [1:0] rand_op();
    int r;
    r = $urandom_range(99);
    if (r < 75) return OP_ABSORB;
    if (r < 88) return OP_ABSORB_FIN;
    if (r < 97) return OP_FIN;
    return OP_NONE;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // empty message, extremes and the unused op
    send_request(OP_FIN, '0);
    send_request(OP_FIN, '1);
    send_request(OP_ABSORB_FIN, '0);
    send_request(OP_ABSORB_FIN, '1);
    send_request(OP_NONE, 64'h5555_5555_5555_5555);
    send_request(OP_ABSORB, '1);
    send_request(OP_ABSORB, '0);
    send_request(OP_NONE, '1);
    send_request(OP_ABSORB, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(OP_FIN, 64'h1234);
    send_request(OP_ABSORB, 64'h8000_0000_0000_0000);
    send_request(OP_ABSORB_FIN, 64'h1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 53; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 53; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < 210; i++) send_request(rand_op(), rand_word());
    end
    send_request(OP_FIN, '0);
    stall_pct = 0;
    while (digests_pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0 && digests_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
